// ===== design/sector_range_access_table_macros.svh =====
// Assertion helpers for the sector range access table
`ifndef SECTOR_RANGE_ACCESS_TABLE_MACROS_SVH
`define SECTOR_RANGE_ACCESS_TABLE_MACROS_SVH

// Implication checked on every rising edge outside reset
`define SRAT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("srat check failed");

// Next-cycle implication checked outside reset
`define SRAT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("srat check failed");

`endif

// ===== design/srat_pkg.sv =====
package srat_pkg;

    localparam logic [1:0] KIND_GRANT = 2'd0;
    localparam logic [1:0] KIND_CHK_RD = 2'd1;
    localparam logic [1:0] KIND_CHK_WR = 2'd2;
    localparam logic [1:0] KIND_READ = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_DENIED = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [15:0] DEV_MASK = 16'hffe0;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the item
        logic clr_scan;  // reset slot pointer and counters
        logic scan_cnt;  // count pass step
        logic scan_mod;  // modify pass step
        logic place;     // place one tail or the new entry
        logic chk_step;  // one check pass step
        logic chk_adv;   // advance check sector
        logic rd_slot;   // latch read result
        logic set_full;
        logic set_deny;
    } srat_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       zero_cnt;
        logic [1:0] kind;
        logic       last_slot;
        logic       room_ok;
        logic       place_more;
        logic       chk_done;
        logic       chk_hit;
        logic       chk_over;
    } srat_sts_t;

endpackage

// ===== design/sector_range_access_table.sv =====
// Channel | Handshake         | Payload
// input   | s_valid / s_ready | s_kind, s_device, s_start_sector, s_sector_count,
//         |                   | s_mode, s_entry_index
// result  | m_valid / m_ready | m_status, m_entry_device, m_entry_start,
//         |                   | m_entry_count, m_entry_mode
//
// One item at a time. Read slot and zero-count items go from dispatch straight to the result.
// A grant runs a count pass, then a modify pass, over the slot table through one pointer,
// then places the split tails and the new entry; a full table is flagged after the count
// pass, before any slot changes.
// A check walks the whole slot table once for each covering entry it steps through.
// Reset (aresetn low, synchronous) empties the table at once via valid bits.
// A stalled result holds; a new item is taken in the cycle the result leaves.
module sector_range_access_table #(
    parameter int MAX_ENTRIES = 16,
    parameter int SECTOR_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [15:0] s_device,
    input  logic [31:0] s_start_sector,
    input  logic [31:0] s_sector_count,
    input  logic [1:0]  s_mode,
    input  logic [3:0]  s_entry_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_entry_device,
    output logic [31:0] m_entry_start,
    output logic [31:0] m_entry_count,
    output logic [1:0]  m_entry_mode
);
    srat_pkg::srat_cmd_t cmd;
    srat_pkg::srat_sts_t sts;

    // sequencer
    srat_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .cmd(cmd), .sts(sts)
    );

    // slot table, item registers and result registers
    srat_datapath #(.MAX_ENTRIES(MAX_ENTRIES), .SECTOR_BITS(SECTOR_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .s_kind(s_kind), .s_device(s_device), .s_start_sector(s_start_sector),
        .s_sector_count(s_sector_count), .s_mode(s_mode),
        .s_entry_index(s_entry_index),
        .r_status(m_status), .r_device(m_entry_device), .r_start(m_entry_start),
        .r_count(m_entry_count), .r_mode(m_entry_mode)
    );
endmodule

// ===== design/srat_datapath.sv =====
module srat_datapath #(
    parameter int MAX_ENTRIES = 16,
    parameter int SECTOR_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  srat_pkg::srat_cmd_t cmd,
    output srat_pkg::srat_sts_t sts,
    input  logic [1:0]         s_kind,
    input  logic [15:0]        s_device,
    input  logic [31:0]        s_start_sector,
    input  logic [31:0]        s_sector_count,
    input  logic [1:0]         s_mode,
    input  logic [3:0]         s_entry_index,
    output logic [1:0]         r_status,
    output logic [15:0]        r_device,
    output logic [31:0]        r_start,
    output logic [31:0]        r_count,
    output logic [1:0]         r_mode
);
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SB = SECTOR_BITS;
    localparam int EW = SECTOR_BITS + 1;
    localparam logic [15:0] DEV_MASK_L = srat_pkg::DEV_MASK;

    // starts are one bit wider: a trimmed front or a split tail may begin past the top
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [15:0]   dev_mem [MAX_ENTRIES];
    logic [EW-1:0] st_mem  [MAX_ENTRIES];
    logic [SB-1:0] cn_mem  [MAX_ENTRIES];
    logic [1:0]    md_mem  [MAX_ENTRIES];
    logic [EW-1:0] tl_st [MAX_ENTRIES];
    logic [SB-1:0] tl_cn [MAX_ENTRIES];
    logic [1:0]    tl_md [MAX_ENTRIES];

    logic [1:0]    kind_reg;
    logic [15:0]   dev_reg;
    logic [SB-1:0] ks_reg, cnt_reg;
    logic [1:0]    mode_reg;
    logic [3:0]    idx_reg;
    logic [IW-1:0] ptr_reg;
    logic [CW-1:0] free_reg, freed_reg, split_reg, nt_reg, pl_reg;
    logic          new_done_reg;
    logic [EW-1:0] sect_reg;
    logic [CW-1:0] steps_reg;
    logic          hit_reg;
    logic [EW-1:0] hend_reg;

    logic [SB-1:0] ks_in, cn_in;
    assign ks_in = SB'(s_start_sector);
    assign cn_in = SB'(s_sector_count);

    logic [EW-1:0] ke;
    assign ke = {1'b0, ks_reg} + {1'b0, cnt_reg};

    // current slot under the pointer
    logic [EW-1:0] cs;
    logic [SB-1:0] cc;
    logic [EW-1:0] ce;
    logic          cv, match, inside_r, split_r;
    assign cs = st_mem[ptr_reg];
    assign cc = cn_mem[ptr_reg];
    assign ce = cs + {1'b0, cc};
    assign cv = valid_reg[ptr_reg];
    assign match = cv && (cs < ke) && (ce > {1'b0, ks_reg})
        && ((dev_mem[ptr_reg] & DEV_MASK_L) == (dev_reg & DEV_MASK_L));
    assign inside_r = (cs >= {1'b0, ks_reg}) && (ce <= ke);
    assign split_r = (cs < {1'b0, ks_reg}) && (ce > ke);

    // pointer wraps to slot 0 after the last slot
    logic          last_w;
    logic [IW-1:0] ptr_inc;
    assign last_w = (ptr_reg == IW'(MAX_ENTRIES - 1));
    assign ptr_inc = last_w ? '0 : ptr_reg + 1'b1;

    logic [IW-1:0] ridx;
    assign ridx = IW'(idx_reg);

    // lowest free slot, priority encoder
    logic [IW-1:0] lf;
    logic          lf_ok;
    always_comb begin
        lf = '0;
        lf_ok = 1'b0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                lf = IW'(i);
                lf_ok = 1'b1;
            end
        end
    end

    // check hit at pointer
    logic chit;
    assign chit = cv && ((dev_mem[ptr_reg] & DEV_MASK_L) == (dev_reg & DEV_MASK_L))
        && ((md_mem[ptr_reg] & (kind_reg == srat_pkg::KIND_CHK_RD ? 2'b01 : 2'b10)) != 2'b00)
        && (sect_reg >= cs) && (sect_reg < ce);

    logic [CW-1:0] need, have;
    assign need = split_reg + CW'(mode_reg != 2'b00);
    assign have = free_reg + freed_reg;

    assign sts.zero_cnt = (cnt_reg == '0);
    assign sts.kind = kind_reg;
    assign sts.last_slot = last_w;
    assign sts.room_ok = ({1'b0, need} <= {1'b0, have});
    assign sts.place_more = (pl_reg < nt_reg) || (mode_reg != 2'b00 && !new_done_reg);
    assign sts.chk_done = (sect_reg >= ke);
    assign sts.chk_hit = hit_reg;
    assign sts.chk_over = (steps_reg > CW'(MAX_ENTRIES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (cmd.scan_mod && match && inside_r) begin
                valid_reg[ptr_reg] <= 1'b0;
            end
            if (cmd.place && lf_ok) begin
                valid_reg[lf] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= s_kind;
            dev_reg <= s_device;
            ks_reg <= ks_in;
            cnt_reg <= cn_in;
            mode_reg <= s_mode;
            idx_reg <= s_entry_index;
            sect_reg <= {1'b0, ks_in};
            r_status <= srat_pkg::ST_OK;
            r_device <= '0;
            r_start <= '0;
            r_count <= '0;
            r_mode <= '0;
        end
        if (cmd.clr_scan) begin
            ptr_reg <= '0;
            free_reg <= '0;
            freed_reg <= '0;
            split_reg <= '0;
            nt_reg <= '0;
            pl_reg <= '0;
            new_done_reg <= 1'b0;
            steps_reg <= '0;
            hit_reg <= 1'b0;
        end
        if (cmd.scan_cnt) begin
            ptr_reg <= ptr_inc;
            if (!cv) free_reg <= free_reg + 1'b1;
            else if (match && inside_r) freed_reg <= freed_reg + 1'b1;
            else if (match && split_r) split_reg <= split_reg + 1'b1;
        end
        if (cmd.scan_mod) begin
            ptr_reg <= ptr_inc;
            if (match && !inside_r) begin
                if (ce <= ke) begin
                    cn_mem[ptr_reg] <= SB'({1'b0, ks_reg} - cs);
                end else if (cs >= {1'b0, ks_reg}) begin
                    st_mem[ptr_reg] <= ke;
                    cn_mem[ptr_reg] <= SB'(ce - ke);
                end else begin
                    tl_st[nt_reg[IW-1:0]] <= ke;
                    tl_cn[nt_reg[IW-1:0]] <= SB'(ce - ke);
                    tl_md[nt_reg[IW-1:0]] <= md_mem[ptr_reg];
                    nt_reg <= nt_reg + 1'b1;
                    cn_mem[ptr_reg] <= SB'({1'b0, ks_reg} - cs);
                end
            end
        end
        if (cmd.place) begin
            if (pl_reg < nt_reg) begin
                dev_mem[lf] <= dev_reg & DEV_MASK_L;
                st_mem[lf] <= tl_st[pl_reg[IW-1:0]];
                cn_mem[lf] <= tl_cn[pl_reg[IW-1:0]];
                md_mem[lf] <= tl_md[pl_reg[IW-1:0]];
                pl_reg <= pl_reg + 1'b1;
            end else begin
                dev_mem[lf] <= dev_reg;
                st_mem[lf] <= {1'b0, ks_reg};
                cn_mem[lf] <= cnt_reg;
                md_mem[lf] <= mode_reg;
                new_done_reg <= 1'b1;
            end
        end
        if (cmd.chk_step) begin
            ptr_reg <= ptr_inc;
            if (chit && !hit_reg) begin
                hit_reg <= 1'b1;
                hend_reg <= ce;
            end
        end
        if (cmd.chk_adv) begin
            sect_reg <= hend_reg;
            steps_reg <= steps_reg + 1'b1;
            ptr_reg <= '0;
            hit_reg <= 1'b0;
        end
        if (cmd.set_full) r_status <= srat_pkg::ST_FULL;
        if (cmd.set_deny) r_status <= srat_pkg::ST_DENIED;
        if (cmd.rd_slot) begin
            if ({28'd0, idx_reg} >= 32'(MAX_ENTRIES) || !valid_reg[ridx]) begin
                r_status <= srat_pkg::ST_EMPTY;
            end else begin
                r_device <= dev_mem[ridx];
                r_start <= 32'(st_mem[ridx]);
                r_count <= 32'(cn_mem[ridx]);
                r_mode <= md_mem[ridx];
            end
        end
    end
endmodule

// ===== design/srat_ctrl.sv =====
module srat_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output srat_pkg::srat_cmd_t cmd,
    input  srat_pkg::srat_sts_t sts
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_CNT  = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_PLC  = 3'd4;
    localparam logic [2:0] S_CHK  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       busy;
    logic       chk_eval_reg;

    // one item at a time; the next is taken as the finished one leaves
    assign busy = (state_reg != S_IDLE) && !(state_reg == S_OUT && m_ready);
    assign s_ready = !busy;
    assign m_valid = (state_reg == S_OUT);

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        cmd.load = s_valid && s_ready;
        case (state_reg)
            S_IDLE, S_OUT: begin
                if (s_valid && s_ready) begin
                    state_next = S_DISP;
                end else if (state_reg == S_OUT && m_ready) begin
                    state_next = S_IDLE;
                end
            end
            S_DISP: begin
                cmd.clr_scan = 1'b1;
                if (sts.kind == srat_pkg::KIND_READ) begin
                    cmd.rd_slot = 1'b1;
                    state_next = S_OUT;
                end else if (sts.zero_cnt) begin
                    state_next = S_OUT;
                end else if (sts.kind == srat_pkg::KIND_GRANT) begin
                    state_next = S_CNT;
                end else begin
                    state_next = S_CHK;
                end
            end
            S_CNT: begin
                cmd.scan_cnt = 1'b1;
                if (sts.last_slot) state_next = S_MOD;
            end
            S_MOD: begin
                if (!sts.room_ok) begin
                    cmd.set_full = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cmd.scan_mod = 1'b1;
                    if (sts.last_slot) state_next = S_PLC;
                end
            end
            S_PLC: begin
                if (sts.place_more) cmd.place = 1'b1;
                else state_next = S_OUT;
            end
            S_CHK: begin
                if (sts.chk_done) begin
                    state_next = S_OUT;
                end else begin
                    cmd.chk_step = 1'b1;
                    if (sts.last_slot) begin
                        cmd.chk_step = 1'b0;
                        state_next = S_CHK;
                    end
                end
                if (!sts.chk_done && sts.last_slot) begin
                    cmd.chk_step = 1'b1;
                    // scan ends this cycle; hit is seen next cycle via S_DISP-free path
                end
            end
            default: state_next = S_IDLE;
        endcase
        // check round ends: evaluate on the cycle after the last slot
        if (state_reg == S_CHK && chk_eval_reg) begin
            cmd.chk_step = 1'b0;
            if (!sts.chk_hit || sts.chk_over) begin
                cmd.set_deny = 1'b1;
                state_next = S_OUT;
            end else begin
                cmd.chk_adv = 1'b1;
                state_next = S_CHK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            chk_eval_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            chk_eval_reg <= (state_reg == S_CHK) && !chk_eval_reg && !sts.chk_done
                && sts.last_slot;
        end
    end
endmodule

// ===== design/srat_checker.sv =====
`include "sector_range_access_table_macros.svh"

module srat_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status
);
    // an accepted item never meets a result still waiting
    `SRAT_ASSERT_IMP(a_no_overlap, s_valid && s_ready, !m_valid || m_ready)
    // the result is never shown right after acceptance
    `SRAT_ASSERT_NEXT(a_not_instant, s_valid && s_ready, !m_valid)
    // a waiting result holds its status
    `SRAT_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_status))
endmodule

bind sector_range_access_table srat_checker u_srat_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status)
);

// ===== dv/testbench.sv =====
module testbench;

    localparam int N_SLOTS  = 16;
    localparam int N_RANDOM = 1420;
    localparam int DRAIN    = 400;

    // one accepted input item
    typedef struct {
        logic [1:0]  kind;
        logic [15:0] device;
        logic [31:0] start;
        logic [31:0] count;
        logic [1:0]  mode;
        logic [3:0]  index;
    } req_t;

    // one result item
    typedef struct {
        logic [1:0]  status;
        logic [15:0] dev;
        logic [31:0] start;
        logic [31:0] count;
        logic [1:0]  mode;
    } resp_t;

    // Table model plus the queue of expected results
    class access_table_sb;
        bit          used[N_SLOTS];
        logic [15:0] s_dev[N_SLOTS];
        logic [32:0] s_start[N_SLOTS];
        logic [32:0] s_count[N_SLOTS];
        logic [1:0]  s_mode[N_SLOTS];
        resp_t       expected_q[$];
        int          errors;

        function new();
            errors = 0;
            foreach (used[i]) used[i] = 0;
        endfunction

        function bit dev_match(logic [15:0] a, logic [15:0] b);
            return (a & srat_pkg::DEV_MASK) == (b & srat_pkg::DEV_MASK);
        endfunction

        function int first_free();
            for (int i = 0; i < N_SLOTS; i++)
                if (!used[i]) return i;
            return -1;
        endfunction

        function void place(int f, logic [15:0] d, logic [32:0] st, logic [32:0] c,
                            logic [1:0] m);
            used[f]    = 1;
            s_dev[f]   = d;
            s_start[f] = st;
            s_count[f] = c;
            s_mode[f]  = m;
        endfunction

        function logic [1:0] grant(logic [15:0] d, logic [31:0] st, logic [31:0] c,
                                   logic [1:0] m);
            logic [32:0] ks, ke, s, e;
            logic [32:0] t_start[N_SLOTS];
            logic [32:0] t_count[N_SLOTS];
            logic [1:0]  t_mode[N_SLOTS];
            int free_n, freed, splits, nt, f;
            ks = {1'b0, st};
            ke = ks + {1'b0, c};
            free_n = 0; freed = 0; splits = 0; nt = 0;
            if (c == 0) return srat_pkg::ST_OK;
            // room test: nothing changes when short
            for (int i = 0; i < N_SLOTS; i++) begin
                if (!used[i]) begin
                    free_n++;
                    continue;
                end
                s = s_start[i];
                e = s + s_count[i];
                if (s >= ke || e <= ks || !dev_match(s_dev[i], d)) continue;
                if (s >= ks && e <= ke) freed++;
                else if (s < ks && e > ke) splits++;
            end
            if (splits + (m != 0) > free_n + freed) return srat_pkg::ST_FULL;
            for (int i = 0; i < N_SLOTS; i++) begin
                if (!used[i]) continue;
                s = s_start[i];
                e = s + s_count[i];
                if (s >= ke || e <= ks || !dev_match(s_dev[i], d)) continue;
                if (s >= ks && e <= ke) begin
                    used[i] = 0;
                end else if (e <= ke) begin
                    s_count[i] = ks - s;
                end else if (s >= ks) begin
                    s_start[i] = ke;
                    s_count[i] = e - ke;
                end else begin
                    t_start[nt] = ke;
                    t_count[nt] = e - ke;
                    t_mode[nt]  = s_mode[i];
                    nt++;
                    s_count[i] = ks - s;
                end
            end
            for (int i = 0; i < nt; i++) begin
                f = first_free();
                if (f >= 0) place(f, d & srat_pkg::DEV_MASK, t_start[i], t_count[i], t_mode[i]);
            end
            if (m != 0) begin
                f = first_free();
                if (f >= 0) place(f, d, ks, {1'b0, c}, m);
            end
            return srat_pkg::ST_OK;
        endfunction

        function logic [1:0] covered(logic [15:0] d, logic [31:0] st, logic [31:0] c,
                                     logic [1:0] perm);
            logic [32:0] sect, stop;
            int steps, hit;
            sect = {1'b0, st};
            stop = sect + {1'b0, c};
            steps = 0;
            while (sect < stop) begin
                if (steps > N_SLOTS) return srat_pkg::ST_DENIED;
                steps++;
                hit = -1;
                for (int i = 0; i < N_SLOTS && hit < 0; i++)
                    if (used[i] && dev_match(s_dev[i], d) && (s_mode[i] & perm) != 0 &&
                        sect >= s_start[i] && sect < s_start[i] + s_count[i])
                        hit = i;
                if (hit < 0) return srat_pkg::ST_DENIED;
                sect = s_start[hit] + s_count[hit];
            end
            return srat_pkg::ST_OK;
        endfunction

        function void note(req_t r);
            resp_t x;
            x = '{srat_pkg::ST_OK, 16'd0, 32'd0, 32'd0, 2'd0};
            case (r.kind)
                srat_pkg::KIND_GRANT:
                    x.status = grant(r.device, r.start, r.count, r.mode);
                srat_pkg::KIND_CHK_RD:
                    x.status = covered(r.device, r.start, r.count, 2'b01);
                srat_pkg::KIND_CHK_WR:
                    x.status = covered(r.device, r.start, r.count, 2'b10);
                default: begin
                    if (!used[r.index]) begin
                        x.status = srat_pkg::ST_EMPTY;
                    end else begin
                        x.dev   = s_dev[r.index];
                        x.start = s_start[r.index][31:0];
                        x.count = s_count[r.index][31:0];
                        x.mode  = s_mode[r.index];
                    end
                end
            endcase
            expected_q.push_back(x);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h want %0h", what, got, want);
            errors++;
        endtask

        task check(resp_t g);
            resp_t x;
            if (expected_q.size() == 0) begin
                report("unexpected item", {30'd0, g.status}, 32'd0);
                return;
            end
            x = expected_q.pop_front();
            if (g.status !== x.status) report("status", {30'd0, g.status}, {30'd0, x.status});
            if (g.dev !== x.dev)       report("entry_device", {16'd0, g.dev}, {16'd0, x.dev});
            if (g.start !== x.start)   report("entry_start", g.start, x.start);
            if (g.count !== x.count)   report("entry_count", g.count, x.count);
            if (g.mode !== x.mode)     report("entry_mode", {30'd0, g.mode}, {30'd0, x.mode});
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_kind = srat_pkg::KIND_GRANT;
    logic [15:0] s_device = 0;
    logic [31:0] s_start_sector = 0;
    logic [31:0] s_sector_count = 0;
    logic [1:0]  s_mode = 0;
    logic [3:0]  s_entry_index = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_status;
    logic [15:0] m_entry_device;
    logic [31:0] m_entry_start;
    logic [31:0] m_entry_count;
    logic [1:0]  m_entry_mode;

    access_table_sb table_sb = new();

    // idle percentages for the current phase
    int send_idle = 0;
    int recv_stall = 0;
    // long receiver hold-off, counted down by the receiver process
    int hold_left = 0;

    sector_range_access_table u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_kind(s_kind), .s_device(s_device), .s_start_sector(s_start_sector),
        .s_sector_count(s_sector_count), .s_mode(s_mode), .s_entry_index(s_entry_index),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_entry_device(m_entry_device),
        .m_entry_start(m_entry_start), .m_entry_count(m_entry_count),
        .m_entry_mode(m_entry_mode)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Generous ceiling: checks can walk the table many times per item
    initial begin
        #60000000;
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off when asked for
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Monitor: both handshakes sampled at the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                table_sb.note('{s_kind, s_device, s_start_sector, s_sector_count,
                                s_mode, s_entry_index});
            if (m_valid && m_ready)
                table_sb.check('{m_status, m_entry_device, m_entry_start,
                                 m_entry_count, m_entry_mode});
        end
    end

    // Offer one item and hold it until taken; returns at the accepting edge
    task automatic offer(logic [1:0] k, logic [15:0] d, logic [31:0] st,
                         logic [31:0] c, logic [1:0] m, logic [3:0] idx);
        s_valid        <= 1'b1;
        s_kind         <= k;
        s_device       <= d;
        s_start_sector <= st;
        s_sector_count <= c;
        s_mode         <= m;
        s_entry_index  <= idx;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Random idle cycles on the sender side before the next item
    task automatic sender_gap();
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Sender stops until every result is back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (table_sb.pending() > 0) @(posedge aclk);
    endtask

    // Random item: mostly a few devices over a narrow sector window so
    // that grants overlap, split and fill the table; the rest is wide noise
    task automatic random_item();
        logic [1:0]  k;
        logic [15:0] d;
        logic [31:0] st, c;
        int r;
        r = $urandom_range(99);
        k = (r < 45) ? srat_pkg::KIND_GRANT : (r < 65) ? srat_pkg::KIND_CHK_RD :
            (r < 85) ? srat_pkg::KIND_CHK_WR : srat_pkg::KIND_READ;
        case ($urandom_range(3))
            0: d = 16'h0000;
            1: d = 16'h0020;
            2: d = 16'hffe0;
            default: d = 16'($urandom);
        endcase
        d[4:0] = 5'($urandom);
        r = $urandom_range(99);
        if (r < 75) begin
            st = $urandom_range(63);
            c  = $urandom_range(24, 1);
        end else if (r < 85) begin
            st = 32'hffff_ffc0 + $urandom_range(63);
            c  = $urandom_range(1, 0) ? $urandom_range(80) : 32'hffff_ffff;
        end else if (r < 92) begin
            st = $urandom;
            c  = $urandom;
        end else begin
            st = $urandom_range(63);
            c  = $urandom_range(1, 0) ? 32'd0 : 32'hffff_ffff;
        end
        offer(k, d, st, c, 2'($urandom), 4'($urandom));
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, no idling
        offer(srat_pkg::KIND_READ,   16'h0040, 0, 0, 2'd0, 4'd0);      // empty slot
        offer(srat_pkg::KIND_GRANT,  16'h0040, 10, 0, 2'd3, 4'd0);     // zero-count grant
        offer(srat_pkg::KIND_CHK_WR, 16'h0040, 10, 0, 2'd0, 4'd0);     // zero-count check
        offer(srat_pkg::KIND_GRANT,  16'h0045, 100, 50, 2'd3, 4'd0);
        offer(srat_pkg::KIND_CHK_RD, 16'h005f, 110, 20, 2'd0, 4'd0);   // partition ignored
        offer(srat_pkg::KIND_CHK_RD, 16'h0060, 110, 20, 2'd0, 4'd0);   // other device
        offer(srat_pkg::KIND_GRANT,  16'h0040, 120, 10, 2'd0, 4'd0);   // revoke splits
        offer(srat_pkg::KIND_READ,   16'h0040, 0, 0, 2'd0, 4'd0);
        offer(srat_pkg::KIND_READ,   16'h0040, 0, 0, 2'd0, 4'd1);
        offer(srat_pkg::KIND_CHK_WR, 16'h0040, 100, 50, 2'd0, 4'd0);   // hole: denied
        offer(srat_pkg::KIND_GRANT,  16'h0041, 90, 15, 2'd1, 4'd0);    // trims front
        offer(srat_pkg::KIND_CHK_RD, 16'h0040, 90, 30, 2'd0, 4'd0);    // walks two entries
        offer(srat_pkg::KIND_CHK_WR, 16'h0040, 90, 30, 2'd0, 4'd0);
        offer(srat_pkg::KIND_GRANT,  16'h0040, 140, 20, 2'd2, 4'd0);   // trims back
        offer(srat_pkg::KIND_GRANT,  16'hffff, 32'hffff_ffff, 32'hffff_ffff, 2'd2, 4'd0);
        offer(srat_pkg::KIND_CHK_WR, 16'hffe0, 32'hffff_ffff, 32'hffff_ffff, 2'd0, 4'd0);
        offer(srat_pkg::KIND_CHK_RD, 16'hffe0, 32'hffff_ffff, 1, 2'd0, 4'd0);
        offer(srat_pkg::KIND_READ,   16'h0000, 0, 0, 2'd0, 4'd15);
        offer(srat_pkg::KIND_READ,   16'h0000, 0, 0, 2'd0, 4'd3);
        offer(srat_pkg::KIND_GRANT,  16'h0040, 0, 32'hffff_ffff, 2'd0, 4'd0);  // revoke all
        offer(srat_pkg::KIND_CHK_RD, 16'h0040, 100, 1, 2'd0, 4'd0);
        offer(srat_pkg::KIND_READ,   16'h0000, 0, 0, 2'd0, 4'd0);

        // random part over four idling phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 58; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 58; end
                default: begin send_idle = 30; recv_stall = 30; end
            endcase
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                if (ph == 0 && n == 100) hold_left = 600;  // block backs up
                if (ph == 1 && n == 150) drain();          // sender waits for results
                sender_gap();
                random_item();
            end
        end

        drain();
        repeat (DRAIN) @(posedge aclk);
        if (table_sb.errors == 0 && table_sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+design
design/srat_pkg.sv
design/srat_datapath.sv
design/srat_ctrl.sv
design/sector_range_access_table.sv
design/srat_checker.sv
dv/testbench.sv
